// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check on the rising clock edge, off while reset is high.
`define MCD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("mcd assertion failed");

// A stalled valid must hold, and the watched signal must stay unchanged.
`define MCD_ASSERT_HOLD(lbl, clk, rst, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    ((vld) && !(rdy) |=> (vld) && $stable(sig))) \
    else $error("mcd stalled item changed");

`endif

// File: hw/rtl/mcd_pkg.sv
// ----------------------------------------------------------------------------
// mcd_pkg
// Event and gesture codes, reset constants and the result type of the
// pointer click and drag detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcd_pkg;

  // Event kinds on the op field.
  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_MOTION  = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // Press kinds.
  localparam logic [1:0] PK_SINGLE = 2'd0;
  localparam logic [1:0] PK_DOUBLE = 2'd1;
  localparam logic [1:0] PK_TRIPLE = 2'd2;

  // Gesture codes on the result.
  localparam logic [3:0] G_MOVE       = 4'd0;
  localparam logic [3:0] G_DOWN       = 4'd1;
  localparam logic [3:0] G_UP         = 4'd2;
  localparam logic [3:0] G_CLICK      = 4'd3;
  localparam logic [3:0] G_DOUBLE     = 4'd4;
  localparam logic [3:0] G_TRIPLE     = 4'd5;
  localparam logic [3:0] G_START_DRAG = 4'd6;
  localparam logic [3:0] G_DRAG       = 4'd7;
  localparam logic [3:0] G_END_DRAG   = 4'd8;

  // Reset value of the drag threshold register.
  localparam logic [15:0] DRAG_THRESHOLD_RESET = 16'd9;

  // Depth of the result buffer.
  localparam int RES_DEPTH_DEFAULT = 4;

  // One result item.
  typedef struct packed {
    logic [3:0]        gesture;
    logic [1:0]        which_button;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/mouse_click_drag_detector.sv
// Results of an accepted item are registered into the result buffer and leave from its head.
// Throughput: one item per cycle while each item gives at most one result and the
// output is not stalled; an item that gives two results writes both into the buffer.
// Results queue in a small buffer; in_ready drops when fewer than two slots are free.
// Reset (rst, synchronous): clears the button state, drag state, flags and the
// buffer, and sets the drag threshold to 9.
// ----------------------------------------------------------------------------
// mouse_click_drag_detector
// Turns pointer press, release and motion events into click, double, triple
// and drag gestures, with up to two result items per event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mouse_click_drag_detector
  import mcd_pkg::*;
#(
  parameter int RES_DEPTH = RES_DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Configuration write
  input  wire logic               cfg_wr_en,
  input  wire logic [15:0]        cfg_wr_data,
  // Input events
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         op,
  input  wire logic [1:0]         press_kind,
  input  wire logic [3:0]         button,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  // Result items
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              gesture,
  output logic [1:0]              which_button,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic                    last
);

  localparam int PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
  localparam int CNT_W = $clog2(RES_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RES_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(RES_DEPTH - 2);

  // Configuration and gesture state.
  logic [15:0]        drag_threshold_sq;
  logic [2:0]         pressed_bits;
  logic [2:0]         pressed_bits_next;
  logic [1:0]         drag_button;
  logic [1:0]         drag_button_next;
  logic signed [15:0] press_x;
  logic signed [15:0] press_y;
  logic               double_flag;
  logic               double_flag_next;
  logic               triple_flag;
  logic               triple_flag_next;
  logic               press_store;

  // Result buffer.
  res_t               res_buf [RES_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   wr_ptr_inc;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  // Per item decode.
  logic               accept;
  logic               pop;
  logic               btn_ok;
  logic [2:0]         btn_mask;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [33:0] sq_x;
  logic signed [33:0] sq_y;
  logic [33:0]        dist_sq;
  logic               past_threshold;
  logic [1:0]         first_pressed;
  res_t               res0;
  res_t               res1;
  logic [1:0]         n_res;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;

  // Button decode: only buttons 1 to 3 are tracked.
  always_comb begin
    btn_ok = 1'b1;
    unique case (button)
      4'd1:    btn_mask = 3'b001;
      4'd2:    btn_mask = 3'b010;
      4'd3:    btn_mask = 3'b100;
      default: begin
        btn_mask = 3'b000;
        btn_ok   = 1'b0;
      end
    endcase
  end

  // Squared distance from the latest press, exact in integers.
  assign dx      = 17'(pos_x) - 17'(press_x);
  assign dy      = 17'(pos_y) - 17'(press_y);
  assign sq_x    = 34'(dx) * 34'(dx);
  assign sq_y    = 34'(dy) * 34'(dy);
  assign dist_sq = $unsigned(sq_x) + $unsigned(sq_y);
  assign past_threshold = dist_sq >= {18'd0, drag_threshold_sq};

  // Lowest-numbered held button.
  always_comb begin
    if (pressed_bits[0]) begin
      first_pressed = 2'd1;
    end else if (pressed_bits[1]) begin
      first_pressed = 2'd2;
    end else if (pressed_bits[2]) begin
      first_pressed = 2'd3;
    end else begin
      first_pressed = 2'd0;
    end
  end

  // Event handling: next state and up to two result items.
  always_comb begin
    pressed_bits_next = pressed_bits;
    drag_button_next  = drag_button;
    double_flag_next  = double_flag;
    triple_flag_next  = triple_flag;
    press_store       = 1'b0;
    n_res             = 2'd0;
    res0 = '{gesture: G_MOVE, which_button: button[1:0], x: pos_x, y: pos_y, last: 1'b0};
    res1 = '{gesture: G_MOVE, which_button: button[1:0], x: pos_x, y: pos_y, last: 1'b1};
    unique case (op)
      OP_PRESS: begin
        pressed_bits_next = pressed_bits | btn_mask;
        press_store       = 1'b1;
        if (press_kind == PK_TRIPLE) begin
          triple_flag_next = 1'b1;
          res0.gesture     = G_TRIPLE;
        end else if (press_kind == PK_DOUBLE) begin
          double_flag_next = 1'b1;
          res0.gesture     = G_DOUBLE;
        end else begin
          res0.gesture     = G_DOWN;
        end
        n_res = btn_ok ? 2'd1 : 2'd0;
      end
      OP_RELEASE: begin
        pressed_bits_next = pressed_bits & ~btn_mask;
        res0.gesture      = G_UP;
        if (drag_button != 2'd0 && {2'b00, drag_button} == button) begin
          // Releasing the dragging button ends the drag; flags stay set.
          res1.gesture     = G_END_DRAG;
          drag_button_next = 2'd0;
          n_res            = 2'd2;
        end else begin
          res1.gesture     = G_CLICK;
          double_flag_next = 1'b0;
          triple_flag_next = 1'b0;
          if (btn_ok) begin
            n_res = (!double_flag && !triple_flag) ? 2'd2 : 2'd1;
          end
        end
      end
      OP_MOTION: begin
        res0.which_button = 2'd0;
        res0.gesture      = G_MOVE;
        n_res             = 2'd1;
        if (drag_button != 2'd0) begin
          res1.gesture      = G_DRAG;
          res1.which_button = drag_button;
          n_res             = 2'd2;
        end else if (past_threshold && first_pressed != 2'd0) begin
          res1.gesture      = G_START_DRAG;
          res1.which_button = first_pressed;
          res1.x            = press_x;
          res1.y            = press_y;
          drag_button_next  = first_pressed;
          n_res             = 2'd2;
        end
      end
      default: begin
        n_res = 2'd0;
      end
    endcase
    res0.last = (n_res == 2'd1);
  end

  // Gesture state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      drag_threshold_sq <= DRAG_THRESHOLD_RESET;
      pressed_bits      <= 3'b000;
      drag_button       <= 2'd0;
      press_x           <= '0;
      press_y           <= '0;
      double_flag       <= 1'b0;
      triple_flag       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        drag_threshold_sq <= cfg_wr_data;
      end
      if (accept) begin
        pressed_bits <= pressed_bits_next;
        drag_button  <= drag_button_next;
        double_flag  <= double_flag_next;
        triple_flag  <= triple_flag_next;
        if (press_store) begin
          press_x <= pos_x;
          press_y <= pos_y;
        end
      end
    end
  end

  // Result buffer pointers and fill count.
  assign wr_ptr_inc = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
  assign in_ready   = (count <= CNT_ROOM);
  assign out_valid  = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        if (n_res == 2'd1) begin
          wr_ptr <= wr_ptr_inc;
        end else if (n_res == 2'd2) begin
          wr_ptr <= (wr_ptr_inc == PTR_LAST) ? '0 : wr_ptr_inc + 1'b1;
        end
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (accept ? CNT_W'(n_res) : '0) - (pop ? CNT_W'(1) : '0);
    end
  end

  // Result buffer storage.
  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) begin
      res_buf[wr_ptr] <= res0;
      if (n_res == 2'd2) begin
        res_buf[wr_ptr_inc] <= res1;
      end
    end
  end

  // Output fields come from the head of the buffer.
  assign gesture      = res_buf[rd_ptr].gesture;
  assign which_button = res_buf[rd_ptr].which_button;
  assign out_x        = res_buf[rd_ptr].x;
  assign out_y        = res_buf[rd_ptr].y;
  assign last         = res_buf[rd_ptr].last;

endmodule

`default_nettype wire

// File: hw/rtl/mcd_checker.sv
// ----------------------------------------------------------------------------
// mcd_checker
// Port-level checks on the result stream of the click and drag detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mcd_checker
  import mcd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] gesture,
  input wire logic [1:0] which_button,
  input wire logic       last
);

  logic move_ok;
  logic opener;
  logic follow_on;

  // Gesture classes used by the checks below.
  assign move_ok   = (gesture == G_MOVE) == (which_button == 2'd0);
  assign opener    = (gesture == G_UP) || (gesture == G_MOVE);
  assign follow_on = (gesture == G_END_DRAG) || (gesture == G_DRAG) ||
                     (gesture == G_START_DRAG) || (gesture == G_CLICK);

  // A move names no button; every other gesture names one of buttons 1 to 3.
  `MCD_ASSERT(a_move_no_button, clk, rst, out_valid |-> move_ok)

  // Only an up or a move is ever followed by a second item of the same event.
  `MCD_ASSERT(a_first_of_two, clk, rst, out_valid && !last |-> opener)

  // Follow-on gestures always close their event.
  `MCD_ASSERT(a_follow_on_last, clk, rst, out_valid && follow_on |-> last)

  // A stalled result item holds.
  `MCD_ASSERT_HOLD(a_out_hold, clk, rst, out_valid, out_ready, {gesture, which_button, last})

endmodule

bind mouse_click_drag_detector mcd_checker u_mcd_checker (.*);

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the pointer click and drag detector. One task
// offers pointer events on the valid/ready input. A behavioral copy of the
// gesture rules predicts the result items of every accepted event, and a
// checker compares each result with the oldest prediction. The tests run in
// this order: directed corner cases, a long output stall, a sweep of drag
// thresholds, and random gesture sequences mixed with noise.
// ----------------------------------------------------------------------------

module tb_top;
  import mcd_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam int TARGET_EVENTS = 1250;

  // Press kind that has no name of its own and acts as a single press.
  localparam logic [1:0] PK_RESERVED = 2'd3;

  // Button numbers.
  localparam logic [3:0] BTN_NONE   = 4'd0;
  localparam logic [3:0] BTN_LEFT   = 4'd1;
  localparam logic [3:0] BTN_MIDDLE = 4'd2;
  localparam logic [3:0] BTN_RIGHT  = 4'd3;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [15:0]        cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         op = OP_NONE;
  logic [1:0]         press_kind = PK_SINGLE;
  logic [3:0]         button = BTN_NONE;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         gesture;
  logic [1:0]         which_button;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic               last;

  // Gesture tracking state of the predictor.
  logic [15:0]        drag_thr = DRAG_THRESHOLD_RESET;
  logic [2:0]         held_btns = '0;
  logic [1:0]         drag_btn = '0;
  logic signed [15:0] anchor_x = '0;
  logic signed [15:0] anchor_y = '0;
  logic               dbl_pending = 1'b0;
  logic               tpl_pending = 1'b0;

  // Predicted gestures, oldest first.
  res_t gesture_q[$];

  int n_events = 0;
  int n_gestures = 0;
  int n_drags = 0;
  int n_bad = 0;
  bit idle_on = 1'b1;
  int sink_hold = 0;

  mouse_click_drag_detector i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .press_kind   (press_kind),
    .button       (button),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .gesture      (gesture),
    .which_button (which_button),
    .out_x        (out_x),
    .out_y        (out_y),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic res_t make_gesture(input logic [3:0] g, input logic [1:0] b,
                                        input logic signed [15:0] x,
                                        input logic signed [15:0] y);
    res_t r;
    r.gesture      = g;
    r.which_button = b;
    r.x            = x;
    r.y            = y;
    r.last         = 1'b0;
    return r;
  endfunction

  // Apply one pointer event to the tracking state and queue its gestures.
  task automatic predict_gestures(input logic [1:0] ev, input logic [1:0] kind,
                                  input logic [3:0] btn, input logic signed [15:0] x,
                                  input logic signed [15:0] y);
    res_t   outs[2];
    int     n;
    logic   known;
    longint dx;
    longint dy;
    longint dist_sq;
    logic [1:0] first;
    n = 0;
    known = (btn >= BTN_LEFT) && (btn <= BTN_RIGHT);
    case (ev)
      OP_PRESS: begin
        if (known) held_btns[btn - 4'd1] = 1'b1;
        anchor_x = x;
        anchor_y = y;
        if (kind == PK_TRIPLE) begin
          tpl_pending = 1'b1;
          if (known) begin
            outs[n] = make_gesture(G_TRIPLE, btn[1:0], x, y);
            n++;
          end
        end else if (kind == PK_DOUBLE) begin
          dbl_pending = 1'b1;
          if (known) begin
            outs[n] = make_gesture(G_DOUBLE, btn[1:0], x, y);
            n++;
          end
        end else if (known) begin
          outs[n] = make_gesture(G_DOWN, btn[1:0], x, y);
          n++;
        end
      end
      OP_RELEASE: begin
        if (known) begin
          held_btns[btn - 4'd1] = 1'b0;
          outs[n] = make_gesture(G_UP, btn[1:0], x, y);
          n++;
        end
        if (drag_btn != 2'd0 && {2'b00, drag_btn} == btn) begin
          // The dragging button ends the drag and keeps the pending flags.
          outs[n] = make_gesture(G_END_DRAG, btn[1:0], x, y);
          n++;
          drag_btn = 2'd0;
        end else begin
          if (known && !dbl_pending && !tpl_pending) begin
            outs[n] = make_gesture(G_CLICK, btn[1:0], x, y);
            n++;
          end
          dbl_pending = 1'b0;
          tpl_pending = 1'b0;
        end
      end
      OP_MOTION: begin
        outs[n] = make_gesture(G_MOVE, 2'd0, x, y);
        n++;
        if (drag_btn != 2'd0) begin
          outs[n] = make_gesture(G_DRAG, drag_btn, x, y);
          n++;
        end else begin
          dx = longint'(x) - longint'(anchor_x);
          dy = longint'(y) - longint'(anchor_y);
          dist_sq = dx * dx + dy * dy;
          if (dist_sq >= longint'(drag_thr)) begin
            // The lowest numbered held button takes the drag.
            if (held_btns[0]) first = 2'd1;
            else if (held_btns[1]) first = 2'd2;
            else if (held_btns[2]) first = 2'd3;
            else first = 2'd0;
            if (first != 2'd0) begin
              drag_btn = first;
              outs[n] = make_gesture(G_START_DRAG, first, anchor_x, anchor_y);
              n++;
              n_drags++;
            end
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      outs[i].last = (i == n - 1);
      gesture_q.push_back(outs[i]);
    end
  endtask

  // Offer one event, after a random gap while idle_on is set, and hold it until it is accepted.
  task automatic send_event(input logic [1:0] ev, input logic [1:0] kind,
                            input logic [3:0] btn, input logic signed [15:0] x,
                            input logic signed [15:0] y);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= ev;
    press_kind <= kind;
    button     <= btn;
    pos_x      <= x;
    pos_y      <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_gestures(ev, kind, btn, x, y);
    n_events++;
  endtask

  // Stop offering and wait until every predicted gesture has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (gesture_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    drag_thr = value;
  endtask

  function automatic logic signed [15:0] near(input logic signed [15:0] v, input int span);
    return 16'(int'(v) + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // One press, some motion near the press point, maybe a chord, then release.
  task automatic random_gesture(input int span);
    logic [3:0]         btn;
    logic [3:0]         other;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    int                 moves;
    btn = 4'($urandom_range(1, 3));
    bx = 16'($urandom);
    by = 16'($urandom);
    send_event(OP_PRESS, 2'($urandom_range(0, 3)), btn, bx, by);
    moves = $urandom_range(0, 4);
    repeat (moves) begin
      send_event(OP_MOTION, 2'($urandom), 4'($urandom), near(bx, span), near(by, span));
    end
    if ($urandom_range(0, 3) == 0) begin
      other = 4'($urandom_range(1, 3));
      send_event(OP_PRESS, 2'($urandom_range(0, 3)), other, near(bx, span), near(by, span));
      send_event(OP_MOTION, 2'($urandom), 4'($urandom), near(bx, span), near(by, span));
      send_event(OP_RELEASE, 2'($urandom), other, near(bx, span), near(by, span));
    end
    send_event(OP_RELEASE, 2'($urandom), btn, near(bx, span), near(by, span));
  endtask

  task automatic send_noise();
    send_event(2'($urandom), 2'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Corner cases of the gesture rules at the reset threshold.
  task automatic test_directed();
    // Just under the threshold, then exactly on it, then a drag and its end.
    send_event(OP_PRESS, PK_SINGLE, BTN_LEFT, 16'sd0, 16'sd0);
    send_event(OP_MOTION, PK_SINGLE, BTN_NONE, 16'sd2, 16'sd2);
    send_event(OP_MOTION, PK_SINGLE, BTN_NONE, 16'sd3, 16'sd0);
    send_event(OP_MOTION, PK_DOUBLE, BTN_LEFT, 16'sd7, -16'sd5);
    send_event(OP_RELEASE, PK_SINGLE, BTN_LEFT, 16'sd7, -16'sd5);
    // Opposite corners of the position range; another button is released
    // while the right button drags, which clicks and leaves the drag alone.
    send_event(OP_PRESS, PK_SINGLE, BTN_RIGHT, 16'h8000, 16'h8000);
    send_event(OP_MOTION, PK_TRIPLE, 4'd15, 16'sh7FFF, 16'sh7FFF);
    send_event(OP_RELEASE, PK_SINGLE, BTN_MIDDLE, 16'sh7FFF, 16'sh7FFF);
    send_event(OP_MOTION, PK_SINGLE, BTN_NONE, 16'sh7FFF, 16'h8000);
    send_event(OP_RELEASE, PK_SINGLE, BTN_RIGHT, 16'sh7FFF, 16'h8000);
    // Double and triple presses; their release gives no click.
    send_event(OP_PRESS, PK_DOUBLE, BTN_MIDDLE, 16'sd100, -16'sd100);
    send_event(OP_RELEASE, PK_SINGLE, BTN_MIDDLE, 16'sd100, -16'sd100);
    send_event(OP_PRESS, PK_TRIPLE, BTN_LEFT, -16'sd1, 16'sd1);
    // A drag ends with the triple flag still pending, so the next release
    // of another button gives no click and then clears the flags.
    send_event(OP_MOTION, PK_SINGLE, BTN_NONE, 16'sd40, 16'sd40);
    send_event(OP_RELEASE, PK_SINGLE, BTN_LEFT, 16'sd40, 16'sd40);
    send_event(OP_PRESS, PK_SINGLE, BTN_MIDDLE, 16'sd5, 16'sd5);
    send_event(OP_RELEASE, PK_SINGLE, BTN_MIDDLE, 16'sd5, 16'sd5);
    // Buttons outside 1 to 3 change the flags and the press point only.
    send_event(OP_PRESS, PK_DOUBLE, BTN_NONE, 16'sd9, 16'sd9);
    send_event(OP_PRESS, PK_TRIPLE, 4'd15, 16'sd9, 16'sd9);
    send_event(OP_RELEASE, PK_SINGLE, 4'd7, 16'sd9, 16'sd9);
    send_event(OP_PRESS, PK_RESERVED, 4'd4, 16'sd9, 16'sd9);
    // The reserved press kind acts as a single press and clicks.
    send_event(OP_PRESS, PK_RESERVED, BTN_RIGHT, 16'sd20, 16'sd20);
    send_event(OP_RELEASE, PK_RESERVED, BTN_RIGHT, 16'sd20, 16'sd20);
    // Far motion with nothing held, then the unused event code.
    send_event(OP_MOTION, PK_SINGLE, BTN_NONE, -16'sd30000, 16'sd30000);
    send_event(OP_NONE, PK_DOUBLE, BTN_LEFT, 16'sd1, 16'sd1);
  endtask

  // Hold the output off for a long stretch while events keep coming.
  task automatic test_backpressure();
    drain_results();
    idle_on = 1'b0;
    sink_hold = 200;
    repeat (8) random_gesture(3);
    drain_results();
    idle_on = 1'b1;
  endtask

  // Probe the threshold compare right at its boundary for several settings.
  task automatic test_thresholds();
    logic [15:0] levels[5];
    int          root;
    levels = '{16'd0, 16'd1, 16'd200, 16'd32768, 16'hFFFF};
    foreach (levels[i]) begin
      drain_results();
      set_threshold(levels[i]);
      root = 0;
      while (root * root < int'(levels[i])) root++;
      send_event(OP_PRESS, PK_SINGLE, BTN_LEFT, 16'sd0, 16'sd0);
      if (root > 0) send_event(OP_MOTION, PK_SINGLE, BTN_NONE, 16'(root - 1), 16'sd0);
      send_event(OP_MOTION, PK_SINGLE, BTN_NONE, 16'(root), 16'sd0);
      send_event(OP_RELEASE, PK_SINGLE, BTN_LEFT, 16'(root), 16'sd0);
      repeat (12) random_gesture(root + 2);
    end
    drain_results();
    set_threshold(DRAG_THRESHOLD_RESET);
  endtask

  // Mostly well formed gestures, some noise, with pauses and new thresholds.
  task automatic test_random();
    int span;
    while (n_events < TARGET_EVENTS) begin
      if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
      if ($urandom_range(0, 49) == 0) begin
        drain_results();
        if ($urandom_range(0, 3) == 0) set_threshold(16'($urandom));
        else set_threshold(16'($urandom_range(0, 100)));
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send_noise();
      end else begin
        case ($urandom_range(0, 2))
          0: span = 2;
          1: span = 12;
          default: span = 300;
        endcase
        random_gesture(span);
      end
    end
    idle_on = 1'b1;
  endtask

  // Output side: random stall after each result while idle_on is set, plus the long hold-off.
  initial begin : result_sink
    int wait_n;
    wait_n = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) wait_n = idle_on ? $urandom_range(0, 3) : 0;
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready <= 1'b0;
      end else if (wait_n > 0) begin
        wait_n--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result with the oldest predicted gesture.
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && out_valid && out_ready) begin
      n_gestures++;
      if (gesture_q.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS) begin
          $display("tb_top: unexpected gesture %0d button %0d at (%0d,%0d) last %0b",
                   gesture, which_button, out_x, out_y, last);
        end
      end else begin
        want = gesture_q.pop_front();
        if (want.gesture !== gesture || want.which_button !== which_button ||
            want.x !== out_x || want.y !== out_y || want.last !== last) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS) begin
            $display("tb_top: mismatch, expected g=%0d b=%0d (%0d,%0d) last=%0b",
                     want.gesture, want.which_button, want.x, want.y, want.last);
            $display("tb_top:           got      g=%0d b=%0d (%0d,%0d) last=%0b",
                     gesture, which_button, out_x, out_y, last);
          end
        end
      end
    end
  end

  initial begin : run
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_thresholds();
    test_random();
    drain_results();
    repeat (10) @(posedge clk);
    $display("tb_top: %0d pointer events in, %0d gestures checked, %0d drags started",
             n_events, n_gestures, n_drags);
    $display("tb_top: thresholds swept from 0 to 65535 with one long output stall, %0d errors",
             n_bad);
    if (n_bad == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
